// ===== sv/sfr_pkg.sv =====
// Shared constants, types and helpers of the sensor frame receiver.
// No dependencies; imported by every module of the block.
package sfr_pkg;

  localparam int HEADER_BYTES = 5;
  localparam int PAYLOAD_MAX  = 32;
  localparam int CFG_W        = 40;
  localparam int CFG_IDX_W    = 2;
  localparam int WIN_W        = (HEADER_BYTES * 8 < CFG_W) ? HEADER_BYTES * 8 : CFG_W;
  localparam int LEN_W        = 6;
  localparam int IDX_W        = $clog2(PAYLOAD_MAX);
  localparam int MEM_AW       = IDX_W + 1;
  localparam int MEM_DEPTH    = 2 * PAYLOAD_MAX;
  localparam int CNT_W        = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;

  // "*Data"
  localparam logic [CFG_W-1:0] HEADER_RESET = 40'h2A_4461_7461;
  localparam logic [LEN_W-1:0] LENGTH_RESET = 6'd8;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // frame command handed from front end to back end
  typedef struct packed {
    logic             err;
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] count;
  } sfr_cmd_t;

  // payload store write from the front end
  typedef struct packed {
    logic              valid;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } sfr_wr_t;

  // bank handed back once its replay has been read out
  typedef struct packed {
    logic valid;
    logic bank;
  } sfr_rel_t;

  // one result word
  typedef struct packed {
    logic             status;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic             last;
    logic [CNT_W-1:0] count;
  } sfr_res_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n;
    if (n == '0) r = LEN_W'(1);
    if (n > LEN_W'(PAYLOAD_MAX)) r = LEN_W'(PAYLOAD_MAX);
    return r;
  endfunction

endpackage

// ===== sv/sfr_front.sv =====
// Front end: config registers, header hunt, payload capture and checksum check.
// Depends on sfr_pkg. Writes the banked payload store, pushes frame commands.
module sfr_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfr_pkg::CFG_W-1:0]       cfg_data_i,
  output sfr_pkg::sfr_wr_t                wr_o,
  output logic                            cmd_push_o,
  output sfr_pkg::sfr_cmd_t               cmd_o,
  input  logic                            cmdq_full_i,
  input  sfr_pkg::sfr_rel_t               rel_i
);
  import sfr_pkg::*;

  logic [CFG_W-1:0] hdr_q;
  logic [LEN_W-1:0] plen_q;
  logic [WIN_W-1:0] win_q, win_d;
  logic             coll_q, coll_d;
  logic [LEN_W-1:0] bc_q, bc_d;
  logic [7:0]       xor_q, xor_d;
  logic [CNT_W-1:0] fc_q, fc_d;
  logic             wr_bank_q, wr_bank_d;
  logic [1:0]       busy_q, busy_d;

  logic [LEN_W-1:0]   len;
  logic               is_data, is_sum, acc, good;
  logic [WIN_W+7:0]   shifted;

  assign len     = eff_len(plen_q);
  assign is_data = coll_q && (bc_q < len);
  assign is_sum  = coll_q && !is_data;
  assign full_o  = (is_data && busy_q[wr_bank_q]) || (is_sum && cmdq_full_i);
  assign acc     = push_i && !full_o;
  assign good    = (rx_byte_i == xor_q);
  assign shifted = {win_q, rx_byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= HEADER_RESET;
      plen_q <= LENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEADER: hdr_q  <= cfg_data_i;
        REG_LENGTH: plen_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    win_d      = win_q;
    coll_d     = coll_q;
    bc_d       = bc_q;
    xor_d      = xor_q;
    fc_d       = fc_q;
    wr_bank_d  = wr_bank_q;
    busy_d     = busy_q;
    wr_o.valid = 1'b0;
    wr_o.addr  = {wr_bank_q, bc_q[IDX_W-1:0]};
    wr_o.data  = rx_byte_i;
    cmd_push_o = 1'b0;
    cmd_o.err  = !good;
    cmd_o.bank = wr_bank_q;
    cmd_o.len  = len;
    cmd_o.count = good ? fc_q + CNT_W'(1) : fc_q;
    if (rel_i.valid) busy_d[rel_i.bank] = 1'b0;
    if (acc) begin
      if (!coll_q) begin
        win_d = shifted[WIN_W-1:0];
        if (win_d == hdr_q[WIN_W-1:0]) begin
          coll_d = 1'b1;
          bc_d   = '0;
          xor_d  = '0;
        end
      end else if (is_data) begin
        wr_o.valid = 1'b1;
        xor_d      = xor_q ^ rx_byte_i;
        bc_d       = bc_q + LEN_W'(1);
      end else begin
        // checksum word closes the frame
        coll_d     = 1'b0;
        win_d      = '0;
        bc_d       = '0;
        xor_d      = '0;
        cmd_push_o = 1'b1;
        if (good) begin
          fc_d              = fc_q + CNT_W'(1);
          busy_d[wr_bank_q] = 1'b1;
          wr_bank_d         = !wr_bank_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      coll_q    <= 1'b0;
      bc_q      <= '0;
      xor_q     <= '0;
      fc_q      <= '0;
      wr_bank_q <= 1'b0;
      busy_q    <= '0;
    end else begin
      win_q     <= win_d;
      coll_q    <= coll_d;
      bc_q      <= bc_d;
      xor_q     <= xor_d;
      fc_q      <= fc_d;
      wr_bank_q <= wr_bank_d;
      busy_q    <= busy_d;
    end
  end

`ifndef ASSERT_OFF
  a_wr_free_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.valid |-> !busy_q[wr_bank_q])
    else $error("payload write into a bank still being replayed");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o |-> !cmdq_full_i)
    else $error("frame command pushed into a full queue");
  a_rel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_i.valid |-> busy_q[rel_i.bank])
    else $error("release of a bank that was not held");
`endif

endmodule

// ===== sv/sfr_cmd_fifo.sv =====
// Two-entry queue of frame commands between front end and back end.
// Depends on sfr_pkg.
module sfr_cmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfr_pkg::sfr_cmd_t  cmd_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output sfr_pkg::sfr_cmd_t  cmd_o
);
  import sfr_pkg::*;

  sfr_cmd_t   slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("command queue count out of range");
`endif

endmodule

// ===== sv/sfr_back.sv =====
// Back end: banked payload store, replay sequencer and two-word result queue.
// Depends on sfr_pkg. Takes frame commands, returns banks to the front end.
module sfr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sfr_pkg::sfr_wr_t             wr_i,
  input  logic                         cmdq_empty_i,
  input  sfr_pkg::sfr_cmd_t            cmd_i,
  output logic                         cmd_pop_o,
  output sfr_pkg::sfr_rel_t            rel_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output sfr_pkg::sfr_res_t            res_o
);
  import sfr_pkg::*;

  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  rdata_q;

  logic             active_q;
  sfr_cmd_t         cur_q;
  logic [IDX_W-1:0] idx_q;
  logic             infl_v_q;
  sfr_res_t         infl_q;

  sfr_res_t   oslot_q [2];
  logic       owp_q, orp_q;
  logic [1:0] ocnt_q;

  logic       out_pop, issue, last, out_push;
  logic [2:0] occ;
  sfr_res_t   push_res;

  assign out_pop   = pop_i && !empty_o;
  assign occ       = {1'b0, ocnt_q} + {2'b0, infl_v_q} - {2'b0, out_pop};
  assign issue     = active_q && (occ < 3'd2);
  assign last      = cur_q.err || (({1'b0, idx_q} + LEN_W'(1)) == cur_q.len);
  assign cmd_pop_o = !active_q && !cmdq_empty_i;
  assign rel_o.valid = issue && last && !cur_q.err;
  assign rel_o.bank  = cur_q.bank;

  // store: one write port from the front, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.valid) mem[wr_i.addr] <= wr_i.data;
    if (issue)      rdata_q <= mem[{cur_q.bank, idx_q}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cur_q <= cmd_i;
    if (issue) begin
      infl_q.status <= cur_q.err ? STATUS_ERR : STATUS_OK;
      infl_q.data   <= '0;
      infl_q.index  <= cur_q.err ? '0 : idx_q;
      infl_q.last   <= last;
      infl_q.count  <= cur_q.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      infl_v_q <= 1'b0;
    end else begin
      infl_v_q <= issue;
      if (cmd_pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (issue) begin
        if (last) active_q <= 1'b0;
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    push_res      = infl_q;
    push_res.data = (infl_q.status == STATUS_ERR) ? 8'd0 : rdata_q;
  end
  assign out_push = infl_v_q;

  assign empty_o = (ocnt_q == 2'd0);
  assign res_o   = oslot_q[orp_q];

  always_ff @(posedge clk_i) begin
    if (out_push) oslot_q[owp_q] <= push_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (out_push) owp_q <= !owp_q;
      if (out_pop)  orp_q <= !orp_q;
      ocnt_q <= ocnt_q + {1'b0, out_push} - {1'b0, out_pop};
    end
  end

`ifndef ASSERT_OFF
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    infl_v_q |-> (ocnt_q < 2'd2) || out_pop)
    else $error("result queue overflow");
  a_issue_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> !issue || idx_q == '0)
    else $error("replay did not start at index zero");
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && cur_q.err |=> !active_q)
    else $error("error command produced more than one word");
`endif

endmodule

// ===== sv/sensor_frame_receiver.sv =====
// Top level of the sensor frame receiver: front end, command queue, back end.
// Depends on sfr_pkg, sfr_front, sfr_cmd_fifo, sfr_back.
//
// channel   direction  handshake            payload
// -------   ---------  -------------------  ---------------------------------------
// input     in         push / full          rx_byte_i
// result    out        empty / pop          status_o payload_byte_o payload_index_o
//                                           last_o good_frames_o
// config    in         cfg_we_i             cfg_idx_i cfg_data_i
//
// Input words are taken one per cycle; the front end holds full only while the
// payload bank it must write next is still being replayed, or at a checksum word
// while the two-entry command queue is full.
// Results leave at one word per cycle while pop is held, set by the single read port of
// the payload store; replay of a frame starts once its command leaves the queue.
// Reset is asynchronous, active low, and needs no clearing pass.
module sensor_frame_receiver (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      rx_byte_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            status_o,
  output logic [7:0]                      payload_byte_o,
  output logic [sfr_pkg::IDX_W-1:0]       payload_index_o,
  output logic                            last_o,
  output logic [sfr_pkg::CNT_W-1:0]       good_frames_o,
  input  logic                            cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfr_pkg::CFG_W-1:0]       cfg_data_i
);
  import sfr_pkg::*;

  sfr_wr_t  wr;
  sfr_rel_t rel;
  sfr_cmd_t cmd_in, cmd_head;
  sfr_res_t res;
  logic     cmd_push, cmd_pop, cmdq_full, cmdq_empty;

  // hunting, capture and checksum; payload goes into one of two banks
  sfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .wr_o        (wr),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmdq_full_i (cmdq_full),
    .rel_i       (rel)
  );

  // one command per finished frame, good or bad
  sfr_cmd_fifo u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmdq_full),
    .pop_i   (cmd_pop),
    .empty_o (cmdq_empty),
    .cmd_o   (cmd_head)
  );

  // replays a bank as a run of words, or emits the single error word
  sfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .cmdq_empty_i (cmdq_empty),
    .cmd_i        (cmd_head),
    .cmd_pop_o    (cmd_pop),
    .rel_o        (rel),
    .empty_o      (empty),
    .pop_i        (pop),
    .res_o        (res)
  );

  assign status_o        = res.status;
  assign payload_byte_o  = res.data;
  assign payload_index_o = res.index;
  assign last_o          = res.last;
  assign good_frames_o   = res.count;

endmodule

// ===== tb/sfr_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard of the sensor frame receiver: follows the byte stream and register
// writes, predicts every result word and compares it with what leaves the block.
// Depends on sfr_pkg.
module sfr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  logic                          full,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          empty,
  input  logic                          pop,
  input  logic                          status_o,
  input  logic [7:0]                    payload_byte_o,
  input  logic [sfr_pkg::IDX_W-1:0]     payload_index_o,
  input  logic                          last_o,
  input  logic [sfr_pkg::CNT_W-1:0]     good_frames_o,
  input  logic                          cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            fail_count,
  output int                            pending
);
  import sfr_pkg::*;

  logic [CFG_W-1:0] hdr_reg;
  logic [LEN_W-1:0] len_reg;
  logic [WIN_W-1:0] window;
  logic             in_frame;
  logic [LEN_W-1:0] taken;
  logic [7:0]       parity;
  logic [7:0]       frame_buf [PAYLOAD_MAX];
  logic [CNT_W-1:0] good_cnt;
  sfr_res_t         words_due [$];

  initial fail_count = 0;

  function automatic int frame_len(input logic [LEN_W-1:0] n);
    if (n == '0) return 1;
    if (n > LEN_W'(PAYLOAD_MAX)) return PAYLOAD_MAX;
    return int'(n);
  endfunction

  task automatic take_byte(input logic [7:0] b);
    int       n;
    sfr_res_t w;
    n = frame_len(len_reg);
    if (!in_frame) begin
      window = WIN_W'({window, b});
      if (window == hdr_reg[WIN_W-1:0]) begin
        in_frame = 1'b1;
        taken    = '0;
        parity   = '0;
      end
    end else if (int'(taken) < n) begin
      frame_buf[taken[IDX_W-1:0]] = b;
      parity ^= b;
      taken++;
    end else begin
      // checksum word closes the frame either way
      in_frame = 1'b0;
      window   = '0;
      taken    = '0;
      if (b != parity) begin
        w.status = STATUS_ERR;
        w.data   = '0;
        w.index  = '0;
        w.last   = 1'b1;
        w.count  = good_cnt;
        words_due.push_back(w);
      end else begin
        good_cnt++;
        for (int k = 0; k < n; k++) begin
          w.status = STATUS_OK;
          w.data   = frame_buf[IDX_W'(k)];
          w.index  = IDX_W'(k);
          w.last   = (k == n - 1);
          w.count  = good_cnt;
          words_due.push_back(w);
        end
      end
      parity = '0;
    end
  endtask

  task automatic check_word();
    sfr_res_t w;
    if (words_due.size() == 0) begin
      $error("result word with nothing expected: status %0d byte 0x%02h index %0d",
             status_o, payload_byte_o, payload_index_o);
      fail_count++;
    end else begin
      w = words_due.pop_front();
      if (status_o !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, status_o);
        fail_count++;
      end
      if (payload_byte_o !== w.data) begin
        $error("payload_byte: expected 0x%02h, got 0x%02h", w.data, payload_byte_o);
        fail_count++;
      end
      if (payload_index_o !== w.index) begin
        $error("payload_index: expected %0d, got %0d", w.index, payload_index_o);
        fail_count++;
      end
      if (last_o !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, last_o);
        fail_count++;
      end
      if (good_frames_o !== w.count) begin
        $error("good_frames: expected %0d, got %0d", w.count, good_frames_o);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_reg  = HEADER_RESET;
      len_reg  = LENGTH_RESET;
      window   = '0;
      in_frame = 1'b0;
      taken    = '0;
      parity   = '0;
      good_cnt = '0;
      words_due.delete();
    end else begin
      if (pop && !empty) check_word();
      if (push && !full) take_byte(rx_byte_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HEADER: hdr_reg = cfg_data_i;
          REG_LENGTH: len_reg = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
    end
    pending = words_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top of the sensor frame receiver: clock, reset, byte stimulus,
// result draining and the verdict. Depends on sfr_pkg, sfr_checker and the block.
module tb_top;
  import sfr_pkg::*;

  // how the two sides hold back during a phase
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // payload content of a frame: random, repeated header bytes, or a fixed byte
  localparam int FILL_RANDOM = -1;
  localparam int FILL_HEADER = -2;

  // the first result word trails its checksum word; keep some margin
  localparam int TAIL_CYCLES = 8;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           rx_byte_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 status_o;
  logic [7:0]           payload_byte_o;
  logic [IDX_W-1:0]     payload_index_o;
  logic                 last_o;
  logic [CNT_W-1:0]     good_frames_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  int fail_count;
  int pending;

  int               send_idle = 0;   // percent of cycles the sender holds off
  int               recv_stall = 0;  // percent of cycles the receiver holds off
  logic [CFG_W-1:0] cur_hdr = HEADER_RESET;
  int               cur_len = 8;     // effective payload length in force
  int               bytes_sent = 0;

  sensor_frame_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .rx_byte_i       (rx_byte_i),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .last_o          (last_o),
    .good_frames_o   (good_frames_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  sfr_checker scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .rx_byte_i       (rx_byte_i),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .last_o          (last_o),
    .good_frames_o   (good_frames_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side: pop is redrawn every cycle, so stalls land on any word of a run
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_stall);
  end

  // Offer one word and hold it until the block takes it. push stays high on
  // return, so back-to-back words go out with no gap unless the sender idles.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] hdr, input int len);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_LENGTH, CFG_W'(len));
    cfg_we_i <= 1'b0;
    cur_hdr = hdr;
    // zero acts as one, anything past the store size as the store size
    cur_len = (len == 0) ? 1 : ((len > PAYLOAD_MAX) ? PAYLOAD_MAX : len);
  endtask

  // Stop sending and wait until every predicted word is out. A header match or
  // payload word makes no result, so give the front end a few quiet cycles too.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle = 0;  recv_stall = 0;  end
      IDLE_SEND: begin send_idle = 76; recv_stall = 0;  end
      IDLE_RECV: begin send_idle = 0;  recv_stall = 76; end
      IDLE_BOTH: begin send_idle = 23; recv_stall = 23; end
      default:   begin send_idle = 0;  recv_stall = 0;  end
    endcase
  endtask

  // Header (its last nhdr bytes), payload of the length in force, checksum.
  task automatic send_frame(input int nhdr, input bit bad, input int fill);
    logic [7:0] b;
    logic [7:0] sum;
    int         k;
    for (k = nhdr - 1; k >= 0; k--) push_byte(cur_hdr[8*k +: 8]);
    sum = '0;
    for (k = 0; k < cur_len; k++) begin
      if (fill == FILL_RANDOM) b = 8'($urandom_range(255));
      else if (fill == FILL_HEADER) b = cur_hdr[8*(HEADER_BYTES - 1 - k % HEADER_BYTES) +: 8];
      else b = 8'(fill);
      sum ^= b;
      push_byte(b);
    end
    push_byte(bad ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  // Mostly well-formed frames with random content; the rest is line noise,
  // headers with one bad byte, and frames with a wrong checksum.
  task automatic run_phase(input logic [CFG_W-1:0] hdr, input int len,
                           input idle_mode_e mode, input int budget, input int nhdr);
    int stop;
    int r;
    int pos;
    int k;
    settle();
    program_regs(hdr, len);
    set_idling(mode);
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      r = $urandom_range(99);
      if (r < 10) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
      end else if (r < 18) begin
        pos = $urandom_range(nhdr - 1);
        for (k = nhdr - 1; k >= 0; k--)
          push_byte((k == pos) ? 8'($urandom_range(255)) : cur_hdr[8*k +: 8]);
      end else begin
        send_frame(nhdr, $urandom_range(99) < 15, FILL_RANDOM);
      end
    end
    // about half the phases stop inside a frame, so the next register write
    // lands while a payload is being collected
    if ($urandom_range(1) == 1) begin
      for (k = nhdr - 1; k >= 0; k--) push_byte(cur_hdr[8*k +: 8]);
      repeat ($urandom_range(1, cur_len)) push_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero length acts as one, byte extremes, good and bad checksum
    settle();
    set_idling(IDLE_NONE);
    program_regs(HEADER_RESET, 0);
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(HEADER_BYTES, 1'b0, 8'hFF);
    send_frame(HEADER_BYTES, 1'b1, 8'h00);
    // header bytes inside the payload must not resync
    settle();
    program_regs(HEADER_RESET, 5);
    send_frame(HEADER_BYTES, 1'b0, FILL_HEADER);

    // random phases; lengths at both ends, all-ones and all-zero headers
    run_phase(HEADER_RESET, 8, IDLE_NONE, 35, HEADER_BYTES);
    run_phase({8'($urandom_range(255)), 32'($urandom)}, 3, IDLE_SEND, 35, HEADER_BYTES);
    run_phase({CFG_W{1'b1}}, PAYLOAD_MAX, IDLE_RECV, 40, HEADER_BYTES);
    // zero header: a cleared window matches on a single zero word
    run_phase('0, 1, IDLE_BOTH, 30, 1);
    // oversize length clamps to the store size
    run_phase({8'($urandom_range(255)), 32'($urandom)}, 63, IDLE_NONE, 40, HEADER_BYTES);
    run_phase({8'($urandom_range(255)), 32'($urandom)}, $urandom_range(1, 6), IDLE_SEND, 40,
              HEADER_BYTES);
    run_phase({8'($urandom_range(255)), 32'($urandom)}, 2, IDLE_RECV, 35, HEADER_BYTES);
    run_phase({8'($urandom_range(255)), 32'($urandom)}, $urandom_range(1, 8), IDLE_BOTH, 40,
              HEADER_BYTES);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("sensor_frame_receiver test passed");
    end else begin
      $display("sensor_frame_receiver test failed");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("sensor_frame_receiver test failed");
    $finish;
  end

endmodule
